@@ rtl/core/pia_pkg.sv @@
// pia_pkg: operation codes, queue entry type and sizing constants of the integer alu
// no dependencies
`default_nettype none
package pia_pkg;
	localparam int unsigned XLEN = 32;
	localparam int unsigned NREGS = 32;
	localparam int unsigned RIDX_W = 5;
	localparam int unsigned QDEPTH = 2;

	typedef enum logic [4:0] {
		OP_ADD = 5'd0, OP_ADDC = 5'd1, OP_ADDE = 5'd2, OP_ADDI = 5'd3, OP_ADDIC = 5'd4,
		OP_ADDIS = 5'd5, OP_ADDME = 5'd6, OP_ADDZE = 5'd7, OP_DIVW = 5'd8, OP_DIVWU = 5'd9,
		OP_MULHW = 5'd10, OP_MULHWU = 5'd11, OP_MULLI = 5'd12, OP_MULLW = 5'd13,
		OP_NEG = 5'd14, OP_SUBF = 5'd15, OP_SUBFC = 5'd16, OP_SUBFE = 5'd17,
		OP_SUBFIC = 5'd18, OP_SUBFME = 5'd19, OP_SUBFZE = 5'd20
	} op_t;

	// classified instruction handed from front to back
	typedef struct packed {
		logic [4:0]  mode;
		logic [4:0]  rd;
		logic [4:0]  ra;
		logic [4:0]  rb;
		logic [15:0] simm;
		logic        oe;
		logic        rec;
		logic        unsup;
		logic        is_div;
		logic        is_mul;
	} pia_instr_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_READ, ST_EXEC, ST_DIV, ST_MUL, ST_DONE
	} pia_state_t;
endpackage
`default_nettype wire

@@ rtl/core/pia_if.sv @@
// pia_if: valid/ready channel carrying a payload of parametrised type
// no dependencies
`default_nettype none
interface pia_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/pia_front.sv @@
// pia_front: accepts instructions, classifies them and queues them for the back end
// depends on pia_pkg
`default_nettype none
module pia_front #(
	parameter int unsigned DEPTH = pia_pkg::QDEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [4:0]       mode,
	input  wire logic [4:0]       dest_index,
	input  wire logic [4:0]       src_a_index,
	input  wire logic [4:0]       src_b_index,
	input  wire logic [15:0]      immediate,
	input  wire logic             overflow_enable,
	input  wire logic             record,
	output logic                  q_valid,
	input  wire logic             q_pop,
	output pia_pkg::pia_instr_t   q_data
);
	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	pia_pkg::pia_instr_t mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   cnt_q;
	pia_pkg::pia_instr_t cls;
	logic push;

	// classify: unsupported forms and the multi-cycle units
	always_comb begin
		cls.mode   = mode;
		cls.rd     = dest_index;
		cls.ra     = src_a_index;
		cls.rb     = src_b_index;
		cls.simm   = immediate;
		cls.oe     = overflow_enable;
		cls.rec    = record;
		cls.is_div = 1'b0;
		cls.is_mul = 1'b0;
		cls.unsup  = 1'b0;
		unique case (mode) inside
			pia_pkg::OP_DIVW, pia_pkg::OP_DIVWU: begin
				cls.is_div = 1'b1;
				cls.unsup  = overflow_enable;
			end
			pia_pkg::OP_MULLW: begin
				cls.is_mul = 1'b1;
				cls.unsup  = overflow_enable;
			end
			pia_pkg::OP_MULHW, pia_pkg::OP_MULHWU, pia_pkg::OP_MULLI: cls.is_mul = 1'b1;
			[pia_pkg::OP_ADD:pia_pkg::OP_ADDZE], [pia_pkg::OP_NEG:pia_pkg::OP_SUBFZE]: ;
			default: cls.unsup = 1'b1;
		endcase
	end

	assign in_ready = (cnt_q != (PW+1)'(DEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != '0);
	assign q_data   = mem_q[rp_q];

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == PW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (q_pop) rp_q <= (rp_q == PW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(q_pop);
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= cls;
	end
endmodule
`default_nettype wire

@@ rtl/core/pia_back.sv @@
// pia_back: register file, xer/cr0/pc state and the execute sequencer
// depends on pia_pkg
`default_nettype none
module pia_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_valid,
	output logic                 q_pop,
	input  pia_pkg::pia_instr_t  q_data,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [31:0]          written_value,
	output logic [4:0]           written_index,
	output logic                 reg_written,
	output logic                 carry_flag,
	output logic                 overflow_flag,
	output logic                 summary_overflow,
	output logic [3:0]           cr0_field,
	output logic [31:0]          next_pc,
	output logic                 unsupported
);
	pia_pkg::pia_state_t st_q, st_d;
	pia_pkg::pia_instr_t ins_q;
	logic [31:0] rf_q [pia_pkg::NREGS];
	logic [pia_pkg::NREGS-1:0] vld_q;
	logic [31:0] a_q, b_q, rda, rdb;
	logic ca_q, ov_q, so_q;
	logic [3:0] cr_q;
	logic [31:0] pc_q;
	// divider
	logic [31:0] quo_q, rem_q, dvs_q;
	logic [5:0]  cnt_q;
	logic        qneg_q;
	logic [32:0] trial;
	// multiplier
	logic [63:0] prod_q;
	logic [32:0] ma, mb;
	// execute
	logic [31:0] x, y, res;
	logic        cin, use_ca, use_ov, wr, rec;
	logic [32:0] sum;
	logic        sov;
	logic [31:0] simm32, res_fin;
	logic        res_wr;
	logic        ld_out;

	assign simm32 = {{16{ins_q.simm[15]}}, ins_q.simm};
	assign rda = vld_q[ins_q.ra] ? rf_q[ins_q.ra] : '0;
	assign rdb = vld_q[ins_q.rb] ? rf_q[ins_q.rb] : '0;

	// adder forms
	always_comb begin
		x = a_q; y = b_q; cin = 1'b0; use_ca = 1'b0; use_ov = 1'b0; rec = ins_q.rec;
		unique case (ins_q.mode) inside
			pia_pkg::OP_ADD: use_ov = ins_q.oe;
			pia_pkg::OP_ADDC: begin use_ca = 1'b1; use_ov = ins_q.oe; end
			pia_pkg::OP_ADDE: begin cin = ca_q; use_ca = 1'b1; use_ov = ins_q.oe; end
			pia_pkg::OP_ADDI: begin
				x = (ins_q.ra != '0) ? a_q : '0; y = simm32; rec = 1'b0;
			end
			pia_pkg::OP_ADDIC: begin y = simm32; use_ca = 1'b1; end
			pia_pkg::OP_ADDIS: begin
				x = (ins_q.ra != '0) ? a_q : '0; y = {ins_q.simm, 16'h0}; rec = 1'b0;
			end
			pia_pkg::OP_ADDME: begin
				y = '1; cin = ca_q; use_ca = 1'b1; use_ov = ins_q.oe;
			end
			pia_pkg::OP_ADDZE: begin
				y = '0; cin = ca_q; use_ca = 1'b1; use_ov = ins_q.oe;
			end
			pia_pkg::OP_NEG: begin x = ~a_q; y = '0; cin = 1'b1; use_ov = ins_q.oe; end
			pia_pkg::OP_SUBF: begin x = ~a_q; cin = 1'b1; use_ov = ins_q.oe; end
			pia_pkg::OP_SUBFC: begin
				x = ~a_q; cin = 1'b1; use_ca = 1'b1; use_ov = ins_q.oe;
			end
			pia_pkg::OP_SUBFE: begin
				x = ~a_q; cin = ca_q; use_ca = 1'b1; use_ov = ins_q.oe;
			end
			pia_pkg::OP_SUBFIC: begin
				x = ~a_q; y = simm32; cin = 1'b1; use_ca = 1'b1; rec = 1'b0;
			end
			pia_pkg::OP_SUBFME: begin
				x = ~a_q; y = '1; cin = ca_q; use_ca = 1'b1; use_ov = ins_q.oe;
			end
			pia_pkg::OP_SUBFZE: begin
				x = ~a_q; y = '0; cin = ca_q; use_ca = 1'b1; use_ov = ins_q.oe;
			end
			pia_pkg::OP_MULLI: rec = 1'b0;
			default: ;
		endcase
		sum = {1'b0, x} + {1'b0, y} + {32'h0, cin};
		sov = ~(x[31] ^ y[31]) & (x[31] ^ sum[31]);
	end

	// result selection for the units
	always_comb begin
		res = sum[31:0];
		wr  = 1'b1;
		unique case (ins_q.mode) inside
			pia_pkg::OP_DIVW, pia_pkg::OP_DIVWU: begin
				res = qneg_q ? (32'h0 - quo_q) : quo_q;
				wr  = (b_q != '0);
			end
			pia_pkg::OP_MULHW, pia_pkg::OP_MULHWU: res = prod_q[63:32];
			pia_pkg::OP_MULLI, pia_pkg::OP_MULLW: res = prod_q[31:0];
			default: ;
		endcase
		res_fin = res;
		res_wr  = wr && !ins_q.unsup;
	end

	assign trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};
	assign ld_out = (st_q == pia_pkg::ST_EXEC) && (!out_valid || out_ready);
	always_comb begin
		ma = {ins_q.mode == pia_pkg::OP_MULHW & a_q[31], a_q};
		mb = (ins_q.mode == pia_pkg::OP_MULLI) ? {simm32[31], simm32}
			: {ins_q.mode == pia_pkg::OP_MULHW & b_q[31], b_q};
	end

	// sequencer next state
	always_comb begin
		st_d  = st_q;
		q_pop = 1'b0;
		unique case (st_q)
			pia_pkg::ST_IDLE: if (q_valid) begin q_pop = 1'b1; st_d = pia_pkg::ST_READ; end
			pia_pkg::ST_READ: begin
				if (ins_q.unsup) st_d = pia_pkg::ST_EXEC;
				else if (ins_q.is_div) st_d = pia_pkg::ST_DIV;
				else if (ins_q.is_mul) st_d = pia_pkg::ST_MUL;
				else st_d = pia_pkg::ST_EXEC;
			end
			pia_pkg::ST_DIV: if (cnt_q == 6'd32) st_d = pia_pkg::ST_EXEC;
			pia_pkg::ST_MUL: st_d = pia_pkg::ST_EXEC;
			pia_pkg::ST_EXEC: if (ld_out) st_d = pia_pkg::ST_IDLE;
			default: st_d = pia_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= pia_pkg::ST_IDLE;
		else st_q <= st_d;
	end

	// operand latch, divider and multiplier datapath
	always_ff @(posedge clk) begin
		if (q_pop) ins_q <= q_data;
		if (st_q == pia_pkg::ST_READ) begin
			a_q <= rda;
			b_q <= rdb;
			cnt_q <= '0;
			if (ins_q.mode == pia_pkg::OP_DIVW) begin
				quo_q  <= rda[31] ? 32'h0 - rda : rda;
				dvs_q  <= rdb[31] ? 32'h0 - rdb : rdb;
				qneg_q <= rda[31] ^ rdb[31];
			end else begin
				quo_q  <= rda;
				dvs_q  <= rdb;
				qneg_q <= 1'b0;
			end
			rem_q <= '0;
		end
		if (st_q == pia_pkg::ST_DIV && cnt_q != 6'd32) begin
			cnt_q <= cnt_q + 6'd1;
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
		if (st_q == pia_pkg::ST_MUL) prod_q <= 64'($signed(ma) * $signed(mb));
	end

	// architectural state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			ca_q      <= 1'b0;
			ov_q      <= 1'b0;
			so_q      <= 1'b0;
			cr_q      <= '0;
			pc_q      <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (ld_out) begin
				out_valid <= 1'b1;
				if (!ins_q.unsup) begin
					pc_q <= pc_q + 32'd4;
					if (res_wr) vld_q[ins_q.rd] <= 1'b1;
					if (use_ca) ca_q <= sum[32];
					if (use_ov) begin
						ov_q <= sov;
						if (sov) so_q <= 1'b1;
					end
					if (res_wr && rec)
						cr_q <= {res_fin[31], !res_fin[31] && res_fin != '0, res_fin == '0,
							so_q | (use_ov & sov)};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out && res_wr) rf_q[ins_q.rd] <= res_fin;
	end

	// output payload, held with the flags so a stall keeps the beat intact
	logic [31:0] wv_q, pco_q;
	logic [4:0]  wi_q;
	logic        rw_q, un_q;
	always_ff @(posedge clk) begin
		if (ld_out) begin
			wv_q  <= res_wr ? res_fin : '0;
			wi_q  <= res_wr ? ins_q.rd : '0;
			rw_q  <= res_wr;
			un_q  <= ins_q.unsup;
			pco_q <= ins_q.unsup ? pc_q : pc_q + 32'd4;
		end
	end

	assign written_value    = wv_q;
	assign written_index    = wi_q;
	assign reg_written      = rw_q;
	assign unsupported      = un_q;
	assign next_pc          = pco_q;
	assign carry_flag       = ca_q;
	assign overflow_flag    = ov_q;
	assign summary_overflow = so_q;
	assign cr0_field        = cr_q;
endmodule
`default_nettype wire

@@ rtl/core/powerpc_integer_alu.sv @@
// powerpc_integer_alu: top level joining the classifying front end and the execute back end
// depends on pia_pkg, pia_if, pia_front, pia_back
//
// usage: one instruction beat enters on in_ch, one result beat leaves on out_ch for each.
// the front end classifies a beat and places it in a two-entry queue; it keeps taking
// beats while the back end works, until the queue is full.
// the back end runs one instruction at a time: pop, register read, a multiply step or
// divide loop where the form needs one, then execute into the result register.
// a multiply forms one registered 33x33 product; a divide takes one quotient bit per
// cycle over 32 steps and leaves its loop once the step counter reaches 32, so the
// divide loop is the slowest path through the back end.
// flags, cr0 and pc on the result beat show the state after that instruction.
// when the receiver stalls the result register holds and the back end waits; the queue
// absorbs further instructions.
// reset clears the register file (per-register valid bits), xer, cr0, pc and the queue.
`default_nettype none
module powerpc_integer_alu #(
	parameter int unsigned QUEUE_DEPTH = pia_pkg::QDEPTH
) (
	input wire logic clk,
	input wire logic arst_n,
	pia_if.sink      in_ch,
	pia_if.source    out_ch
);
	logic q_valid, q_pop;
	pia_pkg::pia_instr_t q_data;

	pia_front #(.DEPTH(QUEUE_DEPTH)) u_front (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.mode(in_ch.data.mode), .dest_index(in_ch.data.dest_index),
		.src_a_index(in_ch.data.src_a_index), .src_b_index(in_ch.data.src_b_index),
		.immediate(in_ch.data.immediate), .overflow_enable(in_ch.data.overflow_enable),
		.record(in_ch.data.record),
		.q_valid, .q_pop, .q_data
	);

	pia_back u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_data,
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.written_value(out_ch.data.written_value), .written_index(out_ch.data.written_index),
		.reg_written(out_ch.data.reg_written), .carry_flag(out_ch.data.carry_flag),
		.overflow_flag(out_ch.data.overflow_flag),
		.summary_overflow(out_ch.data.summary_overflow),
		.cr0_field(out_ch.data.cr0_field), .next_pc(out_ch.data.next_pc),
		.unsupported(out_ch.data.unsupported)
	);
endmodule
`default_nettype wire
